// ===== design/wpc_pkg.sv =====
// ----------------------------------------------------------------------------
// wpc_pkg
// Types and fixed widths shared by the window correlation block.
// ----------------------------------------------------------------------------
package wpc_pkg;

  localparam int VAL_W   = 16;   // raster cell value
  localparam int MAG_W   = 16;   // magnitude of a cell value
  localparam int SA_W    = 27;   // sum of values
  localparam int SAA_W   = 41;   // sum of squares
  localparam int SAB_W   = 42;   // sum of cross products
  localparam int V_W     = 54;   // variance and covariance terms
  localparam int PW      = 144;  // shared multiplier product width
  localparam int YW      = 52;   // shared multiplier digit operand width
  localparam int DIG_W   = 4;    // multiplier digit width
  localparam int SCALE_W = 20;   // result_scale register
  localparam int RES_W   = 21;   // scaled_correlation
  localparam int MBITS   = 20;   // bits of the result magnitude search
  localparam int K_W     = 5;    // search bit index
  localparam int DATA_W  = 32;   // configuration data
  localparam int ADDR_W  = 3;    // configuration byte address

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1000);
  localparam logic               REG_SCALE   = 1'b0;  // register index bit

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SRCH_A,
    ST_SRCH_B,
    ST_EMIT
  } wpc_state_t;

  typedef enum logic [3:0] {
    OP_AA,
    OP_BB,
    OP_AB,
    OP_NAA,
    OP_SAA,
    OP_NBB,
    OP_SBB,
    OP_NAB,
    OP_SASB,
    OP_P,
    OP_CC,
    OP_SS,
    OP_T
  } wpc_op_t;

endpackage

// ===== design/wpc_in_if.sv =====
// ----------------------------------------------------------------------------
// wpc_in_if
// Request channel carrying one cell pair and its window marker.
// ----------------------------------------------------------------------------
interface wpc_in_if
  import wpc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value_a;
  logic                    a_is_null;
  logic signed [VAL_W-1:0] value_b;
  logic                    b_is_null;
  logic                    window_last;

  modport source (output valid, value_a, a_is_null, value_b, b_is_null, window_last,
                  input ready);
  modport sink   (input valid, value_a, a_is_null, value_b, b_is_null, window_last,
                  output ready);
endinterface

// ===== design/wpc_out_if.sv =====
// ----------------------------------------------------------------------------
// wpc_out_if
// Result channel carrying one scaled correlation per window.
// ----------------------------------------------------------------------------
interface wpc_out_if
  import wpc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] scaled_correlation;
  logic                    result_null;

  modport source (output valid, scaled_correlation, result_null, input ready);
  modport sink   (input valid, scaled_correlation, result_null, output ready);
endinterface

// ===== design/window_pearson_correlation_top.sv =====
// ----------------------------------------------------------------------------
// window_pearson_correlation_top
// Windowed Pearson correlation of two rasters, scaled to an integer.
// ----------------------------------------------------------------------------
// Feed the cell pairs of one window, one request each, and mark the final pair
// with window_last. Pairs with both values null are skipped; a single null
// value counts as zero. On the final pair the block returns
// trunc(result_scale * C / sqrt(VA * VB)), 0 when at most one pair counted,
// and result_null = 1 with a zero value when a variance is zero. All products
// run through one shared multiplier that takes a 4-bit digit of one operand
// per cycle and stops once the remaining digits are zero. A skipped pair
// needs no product; a counted pair takes three products. The window end adds
// ten products and a 20-bit magnitude search that alternates ST_SRCH_A and
// ST_SRCH_B for each bit; ST_EMIT then hands the result to the output register
// once it is free. A pending result does not block the request side until
// the next window end.
// ----------------------------------------------------------------------------
module window_pearson_correlation_top
  import wpc_pkg::*;
#(
  parameter int MAX_CELLS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  wpc_in_if.sink              in_ch,
  wpc_out_if.source           out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [ADDR_W-1:0]   cfg_paddr,
  input  logic [DATA_W-1:0]   cfg_pwdata,
  output logic [DATA_W-1:0]   cfg_prdata,
  output logic                cfg_pready
);

  localparam int CNT_W = $clog2(MAX_CELLS + 1);

  // sequencer and accumulators
  wpc_state_t              state_r, state_nxt;
  wpc_op_t                 op_r, op_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic signed [SA_W-1:0]  sa_r, sa_nxt, sb_r, sb_nxt;
  logic [SAA_W-1:0]        saa_r, saa_nxt, sbb_r, sbb_nxt;
  logic signed [SAB_W-1:0] sab_r, sab_nxt;
  logic [SCALE_W-1:0]      scale_r;

  // current pair
  logic [MAG_W-1:0]        amag_r, amag_nxt, bmag_r, bmag_nxt;
  logic                    xneg_r, xneg_nxt, last_r, last_nxt;

  // shared multiplier
  logic [PW-1:0]           mx_r, mx_nxt, acc_r, acc_nxt;
  logic [YW-1:0]           my_r, my_nxt;

  // window end terms
  logic signed [V_W-1:0]   t1_r, t1_nxt, va_r, va_nxt, vb_r, vb_nxt, c_r, c_nxt;
  logic [PW-1:0]           p_r, p_nxt, cc_r, cc_nxt;

  // magnitude search
  logic [PW-1:0]           tt_r, tt_nxt, u_r, u_nxt, w_r, w_nxt, q_r, q_nxt;
  logic [PW-1:0]           cand_r, cand_nxt, cand2;
  logic [MBITS-1:0]        m_r, m_nxt;
  logic [K_W-1:0]          k_r, k_nxt;

  // result
  logic signed [RES_W-1:0] res_r, res_nxt;
  logic                    rnull_r, rnull_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [RES_W-1:0] out_val_r, out_val_nxt;
  logic                    out_null_r, out_null_nxt;

  // combinational helpers
  logic                    ld_en, fin_go, counted;
  wpc_op_t                 ld_op;
  logic [PW-1:0]           opx;
  logic [YW-1:0]           opy;
  logic signed [VAL_W-1:0] in_a, in_b;
  logic [MAG_W-1:0]        in_amag;
  logic [SA_W-1:0]         sa_mag, sb_mag;
  logic [SAB_W-1:0]        sab_mag, acc_sab;
  logic [V_W-1:0]          c_mag, acc_v;
  logic signed [V_W-1:0]   sprod;
  logic [RES_W-1:0]        res_mag;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SCALE) ? DATA_W'(scale_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_SCALE) begin
      scale_r <= cfg_pwdata[SCALE_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // handshake and operand prep
  // --------------------------------------------------------------------------
  assign in_ch.ready               = (state_r == ST_IDLE);
  assign out_ch.valid              = out_valid_r;
  assign out_ch.scaled_correlation = out_val_r;
  assign out_ch.result_null        = out_null_r;

  // a null value counts as zero
  assign in_a    = in_ch.a_is_null ? '0 : in_ch.value_a;
  assign in_b    = in_ch.b_is_null ? '0 : in_ch.value_b;
  assign in_amag = in_a[VAL_W-1] ? MAG_W'(-in_a) : MAG_W'(in_a);
  assign counted = !(in_ch.a_is_null && in_ch.b_is_null) && (n_r < CNT_W'(MAX_CELLS));

  assign sa_mag  = sa_r[SA_W-1]   ? SA_W'(-sa_r)  : SA_W'(sa_r);
  assign sb_mag  = sb_r[SA_W-1]   ? SA_W'(-sb_r)  : SA_W'(sb_r);
  assign sab_mag = sab_r[SAB_W-1] ? SAB_W'(-sab_r) : SAB_W'(sab_r);
  assign c_mag   = c_r[V_W-1]     ? V_W'(-c_r)    : V_W'(c_r);

  assign acc_sab = xneg_r ? SAB_W'(-acc_r[SAB_W-1:0]) : acc_r[SAB_W-1:0];
  assign acc_v   = acc_r[V_W-1:0];
  // signed Sa*Sb from its magnitude
  assign sprod   = (sa_r[SA_W-1] ^ sb_r[SA_W-1]) ? -$signed(acc_v) : $signed(acc_v);

  assign cand2   = cand_r + q_r;
  assign res_mag = res_r[RES_W-1] ? RES_W'(-res_r) : RES_W'(res_r);

  // operand select for the next product
  always_comb begin
    opx = '0;
    opy = '0;
    case (ld_op)
      OP_AA:   begin opx = PW'(in_amag); opy = YW'(in_amag); end
      OP_BB:   begin opx = PW'(bmag_r);  opy = YW'(bmag_r);  end
      OP_AB:   begin opx = PW'(amag_r);  opy = YW'(bmag_r);  end
      OP_NAA:  begin opx = PW'(n_r);     opy = YW'(saa_r);   end
      OP_SAA:  begin opx = PW'(sa_mag);  opy = YW'(sa_mag);  end
      OP_NBB:  begin opx = PW'(n_r);     opy = YW'(sbb_r);   end
      OP_SBB:  begin opx = PW'(sb_mag);  opy = YW'(sb_mag);  end
      OP_NAB:  begin opx = PW'(n_r);     opy = YW'(sab_mag); end
      OP_SASB: begin opx = PW'(sa_mag);  opy = YW'(sb_mag);  end
      OP_P:    begin opx = PW'(va_r);    opy = vb_r[YW-1:0]; end
      OP_CC:   begin opx = PW'(c_mag);   opy = c_mag[YW-1:0]; end
      OP_SS:   begin opx = PW'(scale_r); opy = YW'(scale_r); end
      OP_T:    begin opx = cc_r;         opy = acc_r[YW-1:0]; end
      default: begin opx = '0;           opy = '0;           end
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    n_nxt         = n_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    saa_nxt       = saa_r;
    sbb_nxt       = sbb_r;
    sab_nxt       = sab_r;
    amag_nxt      = amag_r;
    bmag_nxt      = bmag_r;
    xneg_nxt      = xneg_r;
    last_nxt      = last_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    acc_nxt       = acc_r;
    t1_nxt        = t1_r;
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    c_nxt         = c_r;
    p_nxt         = p_r;
    cc_nxt        = cc_r;
    tt_nxt        = tt_r;
    u_nxt         = u_r;
    w_nxt         = w_r;
    q_nxt         = q_r;
    cand_nxt      = cand_r;
    m_nxt         = m_r;
    k_nxt         = k_r;
    res_nxt       = res_r;
    rnull_nxt     = rnull_r;
    out_val_nxt   = out_val_r;
    out_null_nxt  = out_null_r;
    out_valid_nxt = out_valid_r;
    ld_en         = 1'b0;
    ld_op         = OP_AA;
    fin_go        = 1'b0;

    // drop the result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          last_nxt = in_ch.window_last;
          amag_nxt = in_amag;
          bmag_nxt = in_b[VAL_W-1] ? MAG_W'(-in_b) : MAG_W'(in_b);
          xneg_nxt = in_a[VAL_W-1] ^ in_b[VAL_W-1];
          if (counted) begin
            n_nxt  = n_r + CNT_W'(1);
            sa_nxt = sa_r + SA_W'(in_a);
            sb_nxt = sb_r + SA_W'(in_b);
            ld_en  = 1'b1;
            ld_op  = OP_AA;
          end else if (in_ch.window_last) begin
            fin_go = 1'b1;
          end
        end
      end

      ST_MUL: begin
        if (my_r != '0) begin
          // advance one digit
          acc_nxt = acc_r + (mx_r * PW'(my_r[DIG_W-1:0]));
          mx_nxt  = mx_r << DIG_W;
          my_nxt  = my_r >> DIG_W;
        end else begin
          case (op_r)
            OP_AA: begin
              saa_nxt = saa_r + acc_r[SAA_W-1:0];
              ld_en   = 1'b1;
              ld_op   = OP_BB;
            end
            OP_BB: begin
              sbb_nxt = sbb_r + acc_r[SAA_W-1:0];
              ld_en   = 1'b1;
              ld_op   = OP_AB;
            end
            OP_AB: begin
              sab_nxt = sab_r + $signed(acc_sab);
              if (last_r) begin
                fin_go = 1'b1;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
            OP_NAA: begin
              t1_nxt = $signed(acc_v);
              ld_en  = 1'b1;
              ld_op  = OP_SAA;
            end
            OP_SAA: begin
              va_nxt = t1_r - $signed(acc_v);
              ld_en  = 1'b1;
              ld_op  = OP_NBB;
            end
            OP_NBB: begin
              t1_nxt = $signed(acc_v);
              ld_en  = 1'b1;
              ld_op  = OP_SBB;
            end
            OP_SBB: begin
              vb_nxt = t1_r - $signed(acc_v);
              ld_en  = 1'b1;
              ld_op  = OP_NAB;
            end
            OP_NAB: begin
              t1_nxt = sab_r[SAB_W-1] ? -$signed(acc_v) : $signed(acc_v);
              ld_en  = 1'b1;
              ld_op  = OP_SASB;
            end
            OP_SASB: begin
              c_nxt = t1_r - sprod;
              if (va_r[V_W-1] || va_r == '0 || vb_r[V_W-1] || vb_r == '0) begin
                res_nxt   = '0;
                rnull_nxt = 1'b1;
                state_nxt = ST_EMIT;
              end else begin
                ld_en = 1'b1;
                ld_op = OP_P;
              end
            end
            OP_P: begin
              p_nxt = acc_r;
              ld_en = 1'b1;
              ld_op = OP_CC;
            end
            OP_CC: begin
              cc_nxt = acc_r;
              ld_en  = 1'b1;
              ld_op  = OP_SS;
            end
            OP_SS: begin
              ld_en = 1'b1;
              ld_op = OP_T;
            end
            OP_T: begin
              // start the search at the top bit
              tt_nxt    = acc_r;
              u_nxt     = '0;
              w_nxt     = '0;
              q_nxt     = p_r << (2 * (MBITS - 1));
              m_nxt     = '0;
              k_nxt     = K_W'(MBITS - 1);
              state_nxt = ST_SRCH_A;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // trial (m + 2^k)^2 * P = U + W + Q, W = m*P << (k+1), Q = P << 2k
      ST_SRCH_A: begin
        cand_nxt  = u_r + w_r;
        state_nxt = ST_SRCH_B;
      end

      ST_SRCH_B: begin
        if (cand2 <= tt_r) begin
          u_nxt      = cand2;
          w_nxt      = (w_r >> 1) + q_r;
          m_nxt[k_r] = 1'b1;
        end else begin
          w_nxt = w_r >> 1;
        end
        q_nxt = q_r >> 2;
        if (k_r == '0) begin
          res_nxt   = c_r[V_W-1] ? -$signed(RES_W'(m_nxt)) : $signed(RES_W'(m_nxt));
          rnull_nxt = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          k_nxt     = k_r - K_W'(1);
          state_nxt = ST_SRCH_A;
        end
      end

      ST_EMIT: begin
        // hold until the output register is free, then clear the window
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_r;
          out_null_nxt  = rnull_r;
          n_nxt         = '0;
          sa_nxt        = '0;
          sb_nxt        = '0;
          saa_nxt       = '0;
          sbb_nxt       = '0;
          sab_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // window end: too few pairs gives zero right away
    if (fin_go) begin
      if (n_nxt > CNT_W'(1)) begin
        ld_en = 1'b1;
        ld_op = OP_NAA;
      end else begin
        res_nxt   = '0;
        rnull_nxt = 1'b0;
        state_nxt = ST_EMIT;
      end
    end

    // load the shared multiplier
    if (ld_en) begin
      mx_nxt    = opx;
      my_nxt    = opy;
      acc_nxt   = '0;
      op_nxt    = ld_op;
      state_nxt = ST_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_AA;
      n_r         <= '0;
      sa_r        <= '0;
      sb_r        <= '0;
      saa_r       <= '0;
      sbb_r       <= '0;
      sab_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      n_r         <= n_nxt;
      sa_r        <= sa_nxt;
      sb_r        <= sb_nxt;
      saa_r       <= saa_nxt;
      sbb_r       <= sbb_nxt;
      sab_r       <= sab_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amag_r     <= amag_nxt;
    bmag_r     <= bmag_nxt;
    xneg_r     <= xneg_nxt;
    last_r     <= last_nxt;
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    acc_r      <= acc_nxt;
    t1_r       <= t1_nxt;
    va_r       <= va_nxt;
    vb_r       <= vb_nxt;
    c_r        <= c_nxt;
    p_r        <= p_nxt;
    cc_r       <= cc_nxt;
    tt_r       <= tt_nxt;
    u_r        <= u_nxt;
    w_r        <= w_nxt;
    q_r        <= q_nxt;
    cand_r     <= cand_nxt;
    m_r        <= m_nxt;
    k_r        <= k_nxt;
    res_r      <= res_nxt;
    rnull_r    <= rnull_nxt;
    out_val_r  <= out_val_nxt;
    out_null_r <= out_null_nxt;
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_CELLS))
    else $error("pair count beyond window limit");

  a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_null_r |-> out_val_r == '0)
    else $error("null result with nonzero value");

  a_srch_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SRCH_B && k_r == '0 |=> state_r == ST_EMIT)
    else $error("search did not finish at bit zero");

  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && !rnull_r |-> res_mag <= RES_W'(scale_r))
    else $error("result magnitude exceeds scale");

endmodule
